[design/cr3_pkg.sv]
package cr3_pkg;

    localparam int DEF_COEFF_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int IN_W            = 32;
    localparam int Q_BITS          = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [Q_BITS-1:0] SAT_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic [Q_BITS-1:0] SAT_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_UNIQUE   = 2'd0,
        KIND_INFINITE = 2'd1,
        KIND_NONE     = 2'd2
    } kind_t;

    // classification that travels with the determinant magnitudes
    typedef struct packed {
        kind_t      kind;
        logic [2:0] neg;
    } cls_t;

endpackage

[design/cr3_front.sv]
module cr3_front #(
    parameter int COEFF_WIDTH = cr3_pkg::DEF_COEFF_WIDTH,
    localparam int DW = 3*COEFF_WIDTH + 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [cr3_pkg::IN_W-1:0] coef_in [0:11],
    output logic                     det_valid,
    input  logic                     det_ready,
    output logic [DW-1:0]            den_mag,
    output logic [DW-1:0]            num_mag [0:2],
    output cr3_pkg::cls_t            cls
);

    localparam int W   = COEFF_WIDTH;
    localparam int PW  = 2*W;
    localparam int MW  = 2*W + 1;
    localparam int PPW = 2*W + 1;
    localparam int TW  = 3*W + 1;

    // 2x2 minors of rows 2 and 3 over column pairs (rhs is column 3)
    localparam logic [1:0] PI [0:5] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PJ [0:5] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    // row-1 expansion terms, three per determinant: D, Dx, Dy, Dz
    localparam logic [1:0] TC [0:11] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2,
                                         2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    localparam logic [2:0] TM [0:11] = '{3'd3, 3'd1, 3'd0, 3'd3, 3'd5, 3'd4,
                                         3'd5, 3'd1, 3'd2, 3'd4, 3'd2, 3'd0};
    localparam logic TN [0:11] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                   1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    logic [6:0] v_reg;
    logic       adv;

    logic [W-1:0]          raw [0:11];
    logic signed [W-1:0]   c_reg [0:11];
    logic signed [PW-1:0]  pa_reg [0:5];
    logic signed [PW-1:0]  pb_reg [0:5];
    logic signed [W-1:0]   r2_reg [0:3];
    logic signed [MW-1:0]  m_reg [0:5];
    logic signed [W-1:0]   r3_reg [0:3];
    logic signed [PPW-1:0] hi_reg [0:11];
    logic signed [PPW-1:0] lo_reg [0:11];
    logic signed [TW-1:0]  t_reg [0:11];
    logic signed [DW-1:0]  d_reg [0:3];
    logic [DW-1:0]         den_reg;
    logic [DW-1:0]         num_reg [0:2];
    cr3_pkg::cls_t         cls_reg;

    logic signed [DW-1:0]  d_next [0:3];
    logic [DW-1:0]         mag_next [0:3];
    cr3_pkg::cls_t         cls_next;

    generate
        if (W >= cr3_pkg::IN_W) begin : g_wide
            always_comb
            begin
                for (int i = 0; i < 12; i++)
                begin
                    raw[i] = W'(coef_in[i]);
                end
            end
        end else begin : g_narrow
            always_comb
            begin
                for (int i = 0; i < 12; i++)
                begin
                    raw[i] = coef_in[i][W-1:0];
                end
            end
        end
    endgenerate

    assign adv      = !v_reg[6] || det_ready;
    assign in_ready = adv;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d_next[k] = '0;
            for (int t = 0; t < 3; t++)
            begin
                if (TN[k*3+t])
                begin
                    d_next[k] = d_next[k] - DW'(t_reg[k*3+t]);
                end
                else
                begin
                    d_next[k] = d_next[k] + DW'(t_reg[k*3+t]);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            mag_next[k] = d_reg[k][DW-1] ? DW'(-d_reg[k]) : DW'(d_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            cls_next.neg[k] = d_reg[k+1][DW-1] ^ d_reg[0][DW-1];
        end
        if (d_reg[0] != '0)
        begin
            cls_next.kind = cr3_pkg::KIND_UNIQUE;
        end
        else if (d_reg[1] == '0 && d_reg[2] == '0 && d_reg[3] == '0)
        begin
            cls_next.kind = cr3_pkg::KIND_INFINITE;
        end
        else
        begin
            cls_next.kind = cr3_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 12; i++)
            begin
                c_reg[i] <= $signed(raw[i]);
            end
            for (int n = 0; n < 6; n++)
            begin
                pa_reg[n] <= PW'(c_reg[4+PI[n]]) * PW'(c_reg[8+PJ[n]]);
                pb_reg[n] <= PW'(c_reg[4+PJ[n]]) * PW'(c_reg[8+PI[n]]);
                m_reg[n]  <= MW'(pa_reg[n]) - MW'(pb_reg[n]);
            end
            for (int c = 0; c < 4; c++)
            begin
                r2_reg[c] <= c_reg[c];
                r3_reg[c] <= r2_reg[c];
            end
            // split the minor so each product stays near W x W
            for (int t = 0; t < 12; t++)
            begin
                hi_reg[t] <= PPW'(r3_reg[TC[t]]) * PPW'($signed(m_reg[TM[t]][MW-1:W]));
                lo_reg[t] <= PPW'(r3_reg[TC[t]]) * PPW'($signed({1'b0, m_reg[TM[t]][W-1:0]}));
                t_reg[t]  <= (TW'(hi_reg[t]) <<< W) + TW'(lo_reg[t]);
            end
            for (int k = 0; k < 4; k++)
            begin
                d_reg[k] <= d_next[k];
            end
            den_reg <= mag_next[0];
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= mag_next[k+1];
            end
            cls_reg <= cls_next;
        end
    end

    assign det_valid = v_reg[6];
    assign den_mag   = den_reg;
    assign num_mag   = num_reg;
    assign cls       = cls_reg;

endmodule

[design/cr3_queue.sv]
module cr3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cr3_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    rd_reg;
    logic [AW:0]      cnt_reg;
    logic             push;
    logic             pop;

    assign push_ready = cnt_reg != (AW+1)'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count above depth");

endmodule

[design/cr3_back.sv]
module cr3_back #(
    parameter int COEFF_WIDTH = cr3_pkg::DEF_COEFF_WIDTH,
    parameter int FRAC_BITS   = cr3_pkg::DEF_FRAC_BITS,
    localparam int DW = 3*COEFF_WIDTH + 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [DW-1:0]                     den_mag,
    input  logic [DW-1:0]                     num_mag [0:2],
    input  cr3_pkg::cls_t                     cls,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cr3_pkg::Q_BITS-1:0] x_value,
    output logic signed [cr3_pkg::Q_BITS-1:0] y_value,
    output logic signed [cr3_pkg::Q_BITS-1:0] z_value,
    output logic [1:0]                        solution_kind,
    output logic                              saturated
);

    localparam int Q  = cr3_pkg::Q_BITS;
    localparam int RW = DW + Q;
    localparam int NS = Q + 1;

    logic [NS:0]   vld_reg;
    logic          out_vld_reg;
    logic          adv;

    logic [DW-1:0] den0_reg;
    logic [DW-1:0] num0_reg [0:2];
    cr3_pkg::cls_t cls0_reg;

    logic [RW-1:0] rem_reg [1:NS][0:2];
    logic [Q-1:0]  quo_reg [1:NS][0:2];
    logic          ovf_reg [1:NS][0:2];
    logic [DW-1:0] den_reg [1:NS];
    cr3_pkg::cls_t cls_reg [1:NS];

    logic [RW-1:0] rem_nx [1:NS][0:2];
    logic [Q-1:0]  quo_nx [1:NS][0:2];
    logic          ovf_nx [0:2];

    logic [Q-1:0]  val_nx [0:2];
    logic          sat_nx;

    logic [Q-1:0]  x_reg;
    logic [Q-1:0]  y_reg;
    logic [Q-1:0]  z_reg;
    cr3_pkg::kind_t kind_reg;
    logic          sat_reg;

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // restoring division, one quotient bit per stage, bit 31 first
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rem_nx[1][l] = RW'(num0_reg[l]) << FRAC_BITS;
            quo_nx[1][l] = '0;
            ovf_nx[l]    = rem_nx[1][l] >= (RW'(den0_reg) << Q);
        end
        for (int s = 2; s <= NS; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_nx[s][l] = rem_reg[s-1][l];
                quo_nx[s][l] = quo_reg[s-1][l];
                if (rem_reg[s-1][l] >= (RW'(den_reg[s-1]) << (NS - s)))
                begin
                    rem_nx[s][l] = rem_reg[s-1][l] - (RW'(den_reg[s-1]) << (NS - s));
                    quo_nx[s][l][NS-s] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [Q-1:0] lim;
        logic [Q-1:0] mag;
        logic         sat_l;
        lim    = '0;
        mag    = '0;
        sat_l  = 1'b0;
        sat_nx = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            lim   = cls_reg[NS].neg[l] ? cr3_pkg::SAT_MIN : cr3_pkg::SAT_MAX;
            sat_l = ovf_reg[NS][l] || (quo_reg[NS][l] > lim);
            mag   = sat_l ? lim : quo_reg[NS][l];
            val_nx[l] = cls_reg[NS].neg[l] ? Q'(-mag) : mag;
            sat_nx    = sat_nx || sat_l;
            if (cls_reg[NS].kind != cr3_pkg::KIND_UNIQUE)
            begin
                val_nx[l] = '0;
            end
        end
        if (cls_reg[NS].kind != cr3_pkg::KIND_UNIQUE)
        begin
            sat_nx = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NS-1:0], in_valid};
            out_vld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den0_reg <= den_mag;
            num0_reg <= num_mag;
            cls0_reg <= cls;
            den_reg[1] <= den0_reg;
            cls_reg[1] <= cls0_reg;
            for (int l = 0; l < 3; l++)
            begin
                ovf_reg[1][l] <= ovf_nx[l];
            end
            for (int s = 1; s <= NS; s++)
            begin
                rem_reg[s] <= rem_nx[s];
                quo_reg[s] <= quo_nx[s];
            end
            for (int s = 2; s <= NS; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                cls_reg[s] <= cls_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
            x_reg    <= val_nx[0];
            y_reg    <= val_nx[1];
            z_reg    <= val_nx[2];
            kind_reg <= cls_reg[NS].kind;
            sat_reg  <= sat_nx;
        end
    end

    assign out_valid     = out_vld_reg;
    assign x_value       = $signed(x_reg);
    assign y_value       = $signed(y_reg);
    assign z_value       = $signed(z_reg);
    assign solution_kind = kind_reg;
    assign saturated     = sat_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && kind_reg != cr3_pkg::KIND_UNIQUE
        |-> x_reg == '0 && y_reg == '0 && z_reg == '0 && !sat_reg)
        else $error("nonzero values on a singular system");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && sat_reg
        |-> x_reg == cr3_pkg::SAT_MAX || x_reg == cr3_pkg::SAT_MIN
         || y_reg == cr3_pkg::SAT_MAX || y_reg == cr3_pkg::SAT_MIN
         || z_reg == cr3_pkg::SAT_MAX || z_reg == cr3_pkg::SAT_MIN)
        else $error("saturation flag without a clamped value");

endmodule

[design/cramer_rule_3x3_solver_top.sv]
// channel | signals                                         | direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_ready, row{1..3}_{col1..col3,rhs}  | to block
// out     | out_valid, out_ready, x/y/z_value, solution_kind,| from block
//         | saturated                                       |
//
// One item per cycle sustained while the output is not stalled; the path runs through
// 7 determinant stages, the queue, and a 35-stage back end whose 32 restoring
// divide stages (one quotient bit each, three lanes) set the depth.
// Reset clears only valid bits and queue pointers and count; data registers are not reset.
// A stalled output holds the back end; the 4-entry queue lets the front keep
// taking items until it fills.
module cramer_rule_3x3_solver_top #(
    parameter int COEFF_WIDTH = cr3_pkg::DEF_COEFF_WIDTH,
    parameter int FRAC_BITS   = cr3_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cr3_pkg::IN_W-1:0]   row1_col1,
    input  logic signed [cr3_pkg::IN_W-1:0]   row1_col2,
    input  logic signed [cr3_pkg::IN_W-1:0]   row1_col3,
    input  logic signed [cr3_pkg::IN_W-1:0]   row1_rhs,
    input  logic signed [cr3_pkg::IN_W-1:0]   row2_col1,
    input  logic signed [cr3_pkg::IN_W-1:0]   row2_col2,
    input  logic signed [cr3_pkg::IN_W-1:0]   row2_col3,
    input  logic signed [cr3_pkg::IN_W-1:0]   row2_rhs,
    input  logic signed [cr3_pkg::IN_W-1:0]   row3_col1,
    input  logic signed [cr3_pkg::IN_W-1:0]   row3_col2,
    input  logic signed [cr3_pkg::IN_W-1:0]   row3_col3,
    input  logic signed [cr3_pkg::IN_W-1:0]   row3_rhs,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cr3_pkg::Q_BITS-1:0] x_value,
    output logic signed [cr3_pkg::Q_BITS-1:0] y_value,
    output logic signed [cr3_pkg::Q_BITS-1:0] z_value,
    output logic [1:0]                        solution_kind,
    output logic                              saturated
);

    localparam int DW = 3*COEFF_WIDTH + 3;
    localparam int QW = $bits(cr3_pkg::cls_t) + 4*DW;

    logic [cr3_pkg::IN_W-1:0] coef [0:11];

    logic          f_valid;
    logic          f_ready;
    logic [DW-1:0] f_den;
    logic [DW-1:0] f_num [0:2];
    cr3_pkg::cls_t f_cls;

    logic          b_valid;
    logic          b_ready;
    logic [DW-1:0] b_den;
    logic [DW-1:0] b_num [0:2];
    cr3_pkg::cls_t b_cls;

    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;

    assign coef[0]  = row1_col1;
    assign coef[1]  = row1_col2;
    assign coef[2]  = row1_col3;
    assign coef[3]  = row1_rhs;
    assign coef[4]  = row2_col1;
    assign coef[5]  = row2_col2;
    assign coef[6]  = row2_col3;
    assign coef[7]  = row2_rhs;
    assign coef[8]  = row3_col1;
    assign coef[9]  = row3_col2;
    assign coef[10] = row3_col3;
    assign coef[11] = row3_rhs;

    cr3_front #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .coef_in  (coef),
        .det_valid(f_valid),
        .det_ready(f_ready),
        .den_mag  (f_den),
        .num_mag  (f_num),
        .cls      (f_cls)
    );

    assign q_in = {f_cls, f_den, f_num[0], f_num[1], f_num[2]};

    cr3_queue #(
        .WIDTH(QW),
        .DEPTH(cr3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data (q_in),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_data  (q_out)
    );

    assign {b_cls, b_den, b_num[0], b_num[1], b_num[2]} = q_out;

    cr3_back #(
        .COEFF_WIDTH(COEFF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid),
        .in_ready     (b_ready),
        .den_mag      (b_den),
        .num_mag      (b_num),
        .cls          (b_cls),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_value      (x_value),
        .y_value      (y_value),
        .z_value      (z_value),
        .solution_kind(solution_kind),
        .saturated    (saturated)
    );

endmodule
